### src/dddw_pkg.sv
// Shared types and constants for the decimal digit display writer.
// No dependencies; imported by dddw_bcd_unit and decimal_digit_display_writer.
package dddw_pkg;

    localparam int VALUE_WIDTH     = 27;
    localparam int ADDR_WIDTH      = 4;
    localparam int CODE_WIDTH      = 4;
    localparam int DIGIT_COUNT_DEF = 8;
    localparam int BIT_CNT_W       = $clog2(VALUE_WIDTH);

    localparam logic [CODE_WIDTH-1:0] BLANK_CODE = 4'hF;
    localparam logic [CODE_WIDTH-1:0] RADIX      = 4'd10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_OUT
    } t_state;

    // control word from the sequencer to the shared shift unit
    typedef struct packed {
        logic load;   // take a new value, clear the digit register
        logic conv;   // one shift-add-3 step
        logic shift;  // drop the low digit after it has been sent
    } t_unit_ctrl;

    // largest value that fits in dc decimal digits, clipped to the value width;
    // evaluated at elaboration only
    function automatic logic [VALUE_WIDTH-1:0] sat_limit(input int dc);
        longint lim;
        lim = 1;
        for (int i = 0; i < dc; i++) begin
            lim = lim * longint'(RADIX);
        end
        lim = lim - 1;
        if (lim > longint'({VALUE_WIDTH{1'b1}})) begin
            lim = longint'({VALUE_WIDTH{1'b1}});
        end
        return VALUE_WIDTH'(lim);
    endfunction

endpackage

### src/dddw_bcd_unit.sv
// Shared shift unit: saturates the input, runs shift-add-3 conversion one bit
// per step and shifts digits out low first. Depends on dddw_pkg.
module dddw_bcd_unit #(
    parameter int DIGIT_COUNT = dddw_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                 i_clk,
    input  dddw_pkg::t_unit_ctrl                 i_ctrl,
    input  logic [dddw_pkg::VALUE_WIDTH-1:0]     i_value,
    output logic [dddw_pkg::CODE_WIDTH-1:0]      o_low_digit,
    output logic                                 o_rest_zero
);
    import dddw_pkg::*;

    localparam int BCD_W = DIGIT_COUNT * CODE_WIDTH;
    localparam logic [VALUE_WIDTH-1:0] SAT = sat_limit(DIGIT_COUNT);

    logic [VALUE_WIDTH-1:0] r_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       w_adj;

    always_comb begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (r_bcd[i*CODE_WIDTH +: CODE_WIDTH] >= 4'd5) begin
                w_adj[i*CODE_WIDTH +: CODE_WIDTH] = r_bcd[i*CODE_WIDTH +: CODE_WIDTH] + 4'd3;
            end else begin
                w_adj[i*CODE_WIDTH +: CODE_WIDTH] = r_bcd[i*CODE_WIDTH +: CODE_WIDTH];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_bin <= (i_value > SAT) ? SAT : i_value;
            r_bcd <= '0;
        end else if (i_ctrl.conv) begin
            r_bin <= {r_bin[VALUE_WIDTH-2:0], 1'b0};
            if (BCD_W > 1) begin
                r_bcd <= {w_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
            end
        end else if (i_ctrl.shift) begin
            r_bcd <= r_bcd >> CODE_WIDTH;
        end
    end

    assign o_low_digit = r_bcd[CODE_WIDTH-1:0];
    assign o_rest_zero = (r_bcd == '0);

endmodule

### src/decimal_digit_display_writer.sv
// Top level of the decimal digit display writer: sequencer and output word
// register. Depends on dddw_pkg and dddw_bcd_unit.

// One accepted value yields DIGIT_COUNT digit words, position 1 (least
// significant) first; values above the all-nines limit are clamped to it.
// Positions above the highest non-zero digit carry code 15 (blank); zero
// shows a single 0. Each value is loaded, converted one input bit per cycle
// through the shared shift-add-3 unit and then sent one digit word at a
// time whenever the output register is free. The input is not ready from
// acceptance until the last digit word is loaded into the output register;
// that register lets the next value start while the final word still waits.
module decimal_digit_display_writer #(
    parameter int DIGIT_COUNT = dddw_pkg::DIGIT_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [dddw_pkg::VALUE_WIDTH-1:0]  i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dddw_pkg::ADDR_WIDTH-1:0]   o_digit_address,
    output logic [dddw_pkg::CODE_WIDTH-1:0]   o_digit_code,
    output logic                              o_last_write
);
    import dddw_pkg::*;

    t_state                  r_state, n_state;
    t_unit_ctrl              w_ctrl;
    logic [BIT_CNT_W-1:0]    r_bit_cnt, n_bit_cnt;
    logic [ADDR_WIDTH-1:0]   r_pos, n_pos;
    logic                    r_out_valid, n_out_valid;
    logic [ADDR_WIDTH-1:0]   r_addr, n_addr;
    logic [CODE_WIDTH-1:0]   r_code, n_code;
    logic                    r_last, n_last;
    logic                    w_emit;
    logic                    w_pos_last;
    logic                    w_conv_last;
    logic [CODE_WIDTH-1:0]   w_low_digit;
    logic                    w_rest_zero;

    dddw_bcd_unit #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_bcd (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_value     (i_value),
        .o_low_digit (w_low_digit),
        .o_rest_zero (w_rest_zero)
    );

    assign w_pos_last  = (r_pos == ADDR_WIDTH'(DIGIT_COUNT));
    assign w_conv_last = (r_bit_cnt == BIT_CNT_W'(VALUE_WIDTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CONV;
            end
            S_CONV: begin
                if (w_conv_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_emit && w_pos_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs; no word is taken while reset is held
    always_comb begin
        o_ready      = 1'b0;
        w_ctrl       = '0;
        w_emit       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready     = i_rst_n;
                w_ctrl.load = i_valid && i_rst_n;
            end
            S_CONV: begin
                w_ctrl.conv = 1'b1;
            end
            S_OUT: begin
                w_emit       = !r_out_valid || i_ready;
                w_ctrl.shift = w_emit;
            end
            default: ;
        endcase
    end

    // counters and output word
    always_comb begin
        n_bit_cnt   = r_bit_cnt;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_addr      = r_addr;
        n_code      = r_code;
        n_last      = r_last;
        if (w_ctrl.load) begin
            n_bit_cnt = '0;
            n_pos     = ADDR_WIDTH'(1);
        end else if (w_ctrl.conv) begin
            n_bit_cnt = r_bit_cnt + 1'b1;
        end
        if (w_emit) begin
            n_pos       = r_pos + 1'b1;
            n_out_valid = 1'b1;
            n_addr      = r_pos;
            // blank once every digit from here up is zero, except position 1
            n_code      = (r_pos != ADDR_WIDTH'(1) && w_rest_zero) ? BLANK_CODE : w_low_digit;
            n_last      = w_pos_last;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_bit_cnt   <= '0;
            r_pos       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bit_cnt   <= n_bit_cnt;
            r_pos       <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_code <= n_code;
        r_last <= n_last;
    end

    assign o_valid         = r_out_valid;
    assign o_digit_address = r_addr;
    assign o_digit_code    = r_code;
    assign o_last_write    = r_last;

    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_write |-> o_digit_address == ADDR_WIDTH'(DIGIT_COUNT))
        else $error("last word not at top digit position");

    a_no_blank_pos1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_digit_address == ADDR_WIDTH'(1) |-> o_digit_code != BLANK_CODE)
        else $error("position 1 blanked");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_code <= 4'd9 || o_digit_code == BLANK_CODE))
        else $error("illegal digit code");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready while converting");

endmodule

### tb/decimal_digit_display_writer_tb.sv
// Self-checking testbench for decimal_digit_display_writer: checks every digit word of every value
// against a digit-by-digit decimal model or a directed code table, with random idling on both sides.
// Depends on dddw_pkg and the decimal_digit_display_writer RTL.
`timescale 1ns / 1ps

module decimal_digit_display_writer_tb;

    import dddw_pkg::*;

    localparam int DIGITS       = DIGIT_COUNT_DEF;
    localparam int CODES_W      = 4 * DIGITS;
    localparam int RANDOM_ITEMS = 480;
    localparam int TAIL_ITEMS   = 80;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_MAX   = 10;
    localparam int N_DIRECTED   = 20;

    // all nines for eight digits
    localparam logic [VALUE_WIDTH-1:0] SAT_MAX = 27'd99_999_999;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] addr;
        logic [CODE_WIDTH-1:0] code;
        logic                  last;
    } t_digit_word;

    // codes packed with position 1 in the low nibble
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   typed;
        logic [CODES_W-1:0]     codes;
    } t_stim_row;

    localparam t_stim_row DIRECTED [0:N_DIRECTED-1] = '{
        '{27'd0,         1'b1, 32'hFFFF_FFF0},
        '{27'd1,         1'b1, 32'hFFFF_FFF1},
        '{27'd9,         1'b1, 32'hFFFF_FFF9},
        '{27'd10,        1'b1, 32'hFFFF_FF10},
        '{27'd99,        1'b1, 32'hFFFF_FF99},
        '{27'd100,       1'b1, 32'hFFFF_F100},
        '{27'd1000,      1'b0, 32'h0},
        '{27'd7,         1'b0, 32'h0},
        '{27'd12345678,  1'b1, 32'h1234_5678},
        '{27'd87654321,  1'b0, 32'h0},
        '{27'd10000000,  1'b1, 32'h1000_0000},
        '{27'd90000000,  1'b0, 32'h0},
        '{27'd99999998,  1'b0, 32'h0},
        '{27'd99999999,  1'b1, 32'h9999_9999},
        '{27'd100000000, 1'b1, 32'h9999_9999},
        '{27'h7FF_FFFF,  1'b1, 32'h9999_9999},
        '{27'h400_0000,  1'b1, 32'h6710_8864},
        '{27'h555_5555,  1'b0, 32'h0},
        '{27'h2AA_AAAA,  1'b0, 32'h0},
        '{27'd1234567,   1'b1, 32'hF123_4567}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [VALUE_WIDTH-1:0] i_value;
    logic                   o_valid;
    logic                   i_ready;
    logic [ADDR_WIDTH-1:0]  o_digit_address;
    logic [CODE_WIDTH-1:0]  o_digit_code;
    logic                   o_last_write;

    t_digit_word pending_digits [$];
    int          errors        = 0;
    int          quiet_cycles  = 0;
    bit          idle_on       = 1'b1;
    bit          long_hold_req = 1'b0;

    decimal_digit_display_writer #(
        .DIGIT_COUNT(DIGITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digit_address(o_digit_address),
        .o_digit_code   (o_digit_code),
        .o_last_write   (o_last_write)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [CODES_W-1:0] decimal_codes_of(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] n;
        logic [CODES_W-1:0]     c;
        int                     pos;
        n = (v > SAT_MAX) ? SAT_MAX : v;
        c = '0;
        for (pos = 0; pos < DIGITS; pos++) begin
            // position 1 always shows a digit, so zero reads as a single 0
            if (pos == 0 || n != 0) begin
                c[4*pos +: 4] = CODE_WIDTH'(n % 10);
                n = n / 10;
            end else begin
                c[4*pos +: 4] = BLANK_CODE;
            end
        end
        return c;
    endfunction

    task automatic queue_digits(input logic [VALUE_WIDTH-1:0] v, input logic typed,
                                input logic [CODES_W-1:0] codes);
        logic [CODES_W-1:0] c;
        t_digit_word        w;
        int                 pos;
        c = typed ? codes : decimal_codes_of(v);
        for (pos = 1; pos <= DIGITS; pos++) begin
            w.addr = ADDR_WIDTH'(pos);
            w.code = c[4*(pos-1) +: 4];
            w.last = (pos == DIGITS);
            pending_digits.push_back(w);
        end
    endtask

    function automatic logic [VALUE_WIDTH-1:0] random_value();
        int unsigned span;
        int          sel;
        int          k;
        logic [VALUE_WIDTH-1:0] v;
        sel  = $urandom_range(0, 9);
        span = 1;
        if (sel <= 3) begin
            v = VALUE_WIDTH'($urandom);
        end else if (sel <= 6) begin
            // short numbers: exercise leading blanks
            k = $urandom_range(1, DIGITS);
            for (int i = 0; i < k; i++) span = span * 10;
            v = VALUE_WIDTH'($urandom_range(0, span - 1));
        end else if (sel == 7) begin
            v = SAT_MAX - VALUE_WIDTH'($urandom_range(0, 3)) + VALUE_WIDTH'($urandom_range(0, 3));
        end else if (sel == 8) begin
            k = $urandom_range(0, DIGITS - 1);
            for (int i = 0; i < k; i++) span = span * 10;
            v = VALUE_WIDTH'(span + $urandom_range(0, 2) - 1);
        end else begin
            v = VALUE_WIDTH'($urandom_range(int'(SAT_MAX) + 1, (1 << VALUE_WIDTH) - 1));
        end
        return v;
    endfunction

    task automatic send_value(input logic [VALUE_WIDTH-1:0] v, input logic typed,
                              input logic [CODES_W-1:0] codes);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        queue_digits(v, typed, codes);
    endtask

    // receiver: random stall bursts plus one long hold-off to back the block up
    initial begin : rx_side
        int hold_cnt;
        hold_cnt = 0;
        i_ready  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_cnt      = LONG_HOLD - 1;
                i_ready      <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold_cnt = $urandom_range(0, 14);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // output check and stall watchdog
    always @(posedge i_clk) begin
        t_digit_word want;
        if (i_rst_n) begin
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (pending_digits.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < REPORT_MAX) begin
                        $display("unexpected word: addr %0d code %0d last %0b",
                                 o_digit_address, o_digit_code, o_last_write);
                    end
                end else begin
                    want = pending_digits.pop_front();
                    if (o_digit_address !== want.addr || o_digit_code !== want.code ||
                        o_last_write !== want.last) begin
                        errors <= errors + 1;
                        if (errors < REPORT_MAX) begin
                            $display("mismatch: exp a%0d c%0d l%0b, got a%0d c%0d l%0b",
                                     want.addr, want.code, want.last,
                                     o_digit_address, o_digit_code, o_last_write);
                        end
                    end
                end
            end
        end
    end

    initial begin : tx_side
        int k;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++) begin
            send_value(DIRECTED[k].value, DIRECTED[k].typed, DIRECTED[k].codes);
        end

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 100) long_hold_req = 1'b1;
            if (k == RANDOM_ITEMS - TAIL_ITEMS) idle_on = 1'b0;
            send_value(random_value(), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
src/dddw_pkg.sv
src/dddw_bcd_unit.sv
src/decimal_digit_display_writer.sv
tb/decimal_digit_display_writer_tb.sv
